// ----- src/aplm_pkg.sv -----
package aplm_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int CHAN_W     = 4;
  localparam int COEF_W     = 16;
  localparam int WLEN_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int SQ_W       = 35;
  localparam int SUM_W      = 49;
  localparam int ROOT_W     = 25;
  localparam int REM_W      = 29;
  localparam int STEP_W     = 6;
  localparam int ENV_SUM_W  = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd3;

  localparam logic [COEF_W-1:0] ATTACK_RESET = 16'd59541;
  localparam logic [COEF_W-1:0] DECAY_RESET  = 16'd65530;
  localparam logic [WLEN_W-1:0] WINDOW_RESET = 15'd1024;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [CHAN_W-1:0]          sample_channel;
    logic                       buffer_end;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] buffer_peak;
    logic                clip_seen;
    logic [SAMPLE_W-1:0] envelope_level;
    logic [SAMPLE_W-1:0] rms_level;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mag;
    logic                metered;
    logic                last;
  } work_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CALC,
    BK_UPDATE,
    BK_REPORT,
    BK_ROOT,
    BK_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT
  } root_state_t;

endpackage

// ----- src/aplm_front.sv -----
module aplm_front (
  input  logic [aplm_pkg::CHAN_W-1:0] sel_channel,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  aplm_pkg::in_t               in_data,
  input  logic                        q_full,
  output logic                        q_push,
  output aplm_pkg::work_t             q_wdata
);

  logic [aplm_pkg::SAMPLE_W-1:0] raw;

  assign raw      = in_data.sample_value;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // negating the most negative sample lands on the sign bit, which is its true magnitude
  assign q_wdata.mag     = raw[aplm_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  assign q_wdata.metered = (in_data.sample_channel == sel_channel);
  assign q_wdata.last    = in_data.buffer_end;

endmodule

// ----- src/aplm_fifo.sv -----
module aplm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aplm_pkg::work_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output aplm_pkg::work_t rdata
);

  aplm_pkg::work_t mem_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;

  assign full      = (count_r == 3'd4);
  assign not_empty = (count_r != 3'd0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_r + {2'b00, push} - {2'b00, pop};
    end
  end

endmodule

// ----- src/aplm_root.sv -----
module aplm_root #(
  parameter int DIV_W = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [aplm_pkg::SUM_W-1:0]    dividend,
  input  logic [DIV_W-1:0]              divisor,
  output logic                          done,
  output logic [aplm_pkg::SAMPLE_W-1:0] root
);

  aplm_pkg::root_state_t state_r, state_nxt;

  logic [aplm_pkg::SUM_W-1:0]  q_r, q_nxt;
  logic [DIV_W-1:0]            rem_r, rem_nxt;
  logic [DIV_W:0]              shl;
  logic                        div_ge;
  logic [aplm_pkg::SUM_W:0]    sr_r, sr_nxt;
  logic [aplm_pkg::REM_W-1:0]  rad_r, rad_nxt, rem2, trial;
  logic [aplm_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic                        sq_ge;
  logic [aplm_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic [aplm_pkg::SAMPLE_W-1:0] res_r, res_nxt;

  assign done = done_r;
  assign root = res_r;

  // one quotient bit per step
  assign shl    = {rem_r, q_r[aplm_pkg::SUM_W-1]};
  assign div_ge = (shl >= {1'b0, divisor});

  // one root bit per step, two radicand bits in
  assign rem2  = {rad_r[aplm_pkg::REM_W-3:0], sr_r[aplm_pkg::SUM_W:aplm_pkg::SUM_W-1]};
  assign trial = {2'b00, root_r, 2'b01};
  assign sq_ge = (rem2 >= trial);

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    sr_nxt    = sr_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    case (state_r)
      aplm_pkg::RT_IDLE: begin
        if (start) begin
          q_nxt     = dividend;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = aplm_pkg::RT_DIV;
        end
      end
      aplm_pkg::RT_DIV: begin
        rem_nxt = div_ge ? DIV_W'(shl - {1'b0, divisor}) : DIV_W'(shl);
        q_nxt   = {q_r[aplm_pkg::SUM_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == aplm_pkg::STEP_W'(aplm_pkg::SUM_W - 1)) begin
          sr_nxt    = {1'b0, q_nxt};
          rad_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = aplm_pkg::RT_SQRT;
        end
      end
      aplm_pkg::RT_SQRT: begin
        rad_nxt  = sq_ge ? (rem2 - trial) : rem2;
        root_nxt = {root_r[aplm_pkg::ROOT_W-2:0], sq_ge};
        sr_nxt   = {sr_r[aplm_pkg::SUM_W-2:0], 2'b00};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == aplm_pkg::STEP_W'(aplm_pkg::ROOT_W - 1)) begin
          res_nxt   = root_nxt[aplm_pkg::SAMPLE_W-1:0];
          done_nxt  = 1'b1;
          state_nxt = aplm_pkg::RT_IDLE;
        end
      end
      default: state_nxt = aplm_pkg::RT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    sr_r   <= sr_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    if (!rst_n) begin
      state_r <= aplm_pkg::RT_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// ----- src/aplm_back.sv -----
module aplm_back #(
  parameter int WINDOW_MAX = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [aplm_pkg::COEF_W-1:0]   attack_coef,
  input  logic [aplm_pkg::COEF_W-1:0]   decay_coef,
  input  logic [aplm_pkg::WLEN_W-1:0]   window_length,
  input  logic                          window_wr,
  input  logic                          q_not_empty,
  input  aplm_pkg::work_t               q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output aplm_pkg::out_t                out_data
);

  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW = $clog2(WINDOW_MAX + 1);

  aplm_pkg::back_state_t state_r, state_nxt;

  logic [aplm_pkg::SQ_W-1:0]     ring_mem [WINDOW_MAX];
  logic [aplm_pkg::SQ_W-1:0]     rdata_r;
  logic                          ring_we;

  aplm_pkg::work_t               item_r, item_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic                          wrapped_r, wrapped_nxt;
  logic [aplm_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [aplm_pkg::SAMPLE_W-1:0] env_r, env_nxt, peak_r, peak_nxt;
  logic                          clip_r, clip_nxt;
  logic [aplm_pkg::SQ_W-1:0]     sq_r, sq_nxt, prod_att_r, prod_att_nxt;
  logic [aplm_pkg::SQ_W-2:0]     prod_fb_r, prod_fb_nxt;
  logic [aplm_pkg::COEF_W-1:0]   coef;
  logic [aplm_pkg::COEF_W:0]     coef_inv;
  logic [aplm_pkg::ENV_SUM_W-1:0] env_sum;
  logic [aplm_pkg::SQ_W-1:0]     old_sq;
  logic [EW-1:0]                 win_eff, pos_inc;
  aplm_pkg::out_t                rep_r, rep_nxt, out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          root_start, root_done;
  logic [aplm_pkg::SAMPLE_W-1:0] root_val;

  always_comb begin
    if (window_length == '0) begin
      win_eff = EW'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      win_eff = EW'(WINDOW_MAX);
    end else begin
      win_eff = EW'(window_length);
    end
  end

  assign coef     = (item_r.mag > env_r) ? attack_coef : decay_coef;
  assign coef_inv = 17'h10000 - {1'b0, coef};
  assign env_sum  = aplm_pkg::ENV_SUM_W'(prod_att_r) + aplm_pkg::ENV_SUM_W'(prod_fb_r)
                    + aplm_pkg::ENV_SUM_W'(32768);
  // entries past the write point since the last clear were never written: read as zero
  assign old_sq   = wrapped_r ? rdata_r : '0;
  assign pos_inc  = EW'(pos_r) + 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    pos_nxt       = pos_r;
    wrapped_nxt   = wrapped_r;
    sum_nxt       = sum_r;
    env_nxt       = env_r;
    peak_nxt      = peak_r;
    clip_nxt      = clip_r;
    sq_nxt        = sq_r;
    prod_att_nxt  = prod_att_r;
    prod_fb_nxt   = prod_fb_r;
    rep_nxt       = rep_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    ring_we       = 1'b0;
    root_start    = 1'b0;
    case (state_r)
      aplm_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_rdata;
          if (q_rdata.metered) begin
            state_nxt = aplm_pkg::BK_CALC;
          end else if (q_rdata.last) begin
            state_nxt = aplm_pkg::BK_REPORT;
          end
        end
      end
      aplm_pkg::BK_CALC: begin
        sq_nxt       = aplm_pkg::SQ_W'(item_r.mag) * aplm_pkg::SQ_W'(item_r.mag);
        prod_att_nxt = aplm_pkg::SQ_W'(item_r.mag) * aplm_pkg::SQ_W'(coef_inv);
        prod_fb_nxt  = (aplm_pkg::SQ_W-1)'(coef) * (aplm_pkg::SQ_W-1)'(env_r);
        state_nxt    = aplm_pkg::BK_UPDATE;
      end
      aplm_pkg::BK_UPDATE: begin
        ring_we = 1'b1;
        sum_nxt = sum_r + aplm_pkg::SUM_W'(sq_r) - aplm_pkg::SUM_W'(old_sq);
        if (pos_inc >= win_eff) begin
          pos_nxt     = '0;
          wrapped_nxt = 1'b1;
        end else begin
          pos_nxt = PW'(pos_inc);
        end
        env_nxt = env_sum[aplm_pkg::SAMPLE_W+15:16];
        if (item_r.mag > peak_r) peak_nxt = item_r.mag;
        if (item_r.mag[aplm_pkg::SAMPLE_W-1:aplm_pkg::SAMPLE_W-2] != 2'b00) clip_nxt = 1'b1;
        state_nxt = item_r.last ? aplm_pkg::BK_REPORT : aplm_pkg::BK_IDLE;
      end
      aplm_pkg::BK_REPORT: begin
        rep_nxt.buffer_peak    = peak_r;
        rep_nxt.clip_seen      = clip_r;
        rep_nxt.envelope_level = env_r;
        rep_nxt.rms_level      = '0;
        peak_nxt   = '0;
        clip_nxt   = 1'b0;
        root_start = 1'b1;
        state_nxt  = aplm_pkg::BK_ROOT;
      end
      aplm_pkg::BK_ROOT: begin
        if (root_done) begin
          rep_nxt.rms_level = root_val;
          state_nxt         = aplm_pkg::BK_DONE;
        end
      end
      aplm_pkg::BK_DONE: begin
        // hold until the output register has been taken
        if (!out_valid_r || !out_stall) begin
          out_nxt       = rep_r;
          out_valid_nxt = 1'b1;
          state_nxt     = aplm_pkg::BK_IDLE;
        end
      end
      default: state_nxt = aplm_pkg::BK_IDLE;
    endcase
    if (window_wr) begin
      pos_nxt     = '0;
      wrapped_nxt = 1'b0;
      sum_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[pos_r] <= sq_r;
    end
    rdata_r <= ring_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    sq_r       <= sq_nxt;
    prod_att_r <= prod_att_nxt;
    prod_fb_r  <= prod_fb_nxt;
    rep_r      <= rep_nxt;
    out_r      <= out_nxt;
    if (!rst_n) begin
      state_r     <= aplm_pkg::BK_IDLE;
      pos_r       <= '0;
      wrapped_r   <= 1'b0;
      sum_r       <= '0;
      env_r       <= '0;
      peak_r      <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      wrapped_r   <= wrapped_nxt;
      sum_r       <= sum_nxt;
      env_r       <= env_nxt;
      peak_r      <= peak_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  aplm_root #(
    .DIV_W (EW)
  ) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (sum_r),
    .divisor  (win_eff),
    .done     (root_done),
    .root     (root_val)
  );

endmodule

// ----- src/audio_peak_rms_level_meter_unit.sv -----
// Audio level meter: peak, clip, envelope and sliding-window RMS for one channel.
// Input channel (in_valid / in_stall / in_data): one sample request per accepted
// edge. Samples of other channels than the selected one change nothing; a request
// with buffer_end set always yields one report on the output channel.
// Output channel (out_valid / out_stall / out_data): report held in a register
// until taken; requests are still accepted meanwhile until the queue is full.
// The front computes the magnitude and channel match and writes into a four-entry
// queue; it takes one request per cycle while the queue has room.
// The back handles a metered sample in its ring read, multiply and update steps and
// an unmetered one on its pop alone. A report adds a 49-step restoring divide
// by the window length and a 25-step square root, one bit each.
// Configuration (cfg_we / cfg_index / cfg_wdata) is to be written while idle; the
// block does not enforce it; a window write empties the ring and the running sum.
// Reset (rst_n low, synchronous) empties the queue, clears envelope, peak, clip,
// sum and ring position, and loads the register defaults. No clearing pass.
module audio_peak_rms_level_meter_unit #(
  parameter int WINDOW_MAX = 16384
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  aplm_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output aplm_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [aplm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aplm_pkg::COEF_W-1:0]      cfg_wdata
);

  logic [aplm_pkg::CHAN_W-1:0] channel_r;
  logic [aplm_pkg::COEF_W-1:0] attack_r, decay_r;
  logic [aplm_pkg::WLEN_W-1:0] window_r;
  logic                        window_wr;

  logic            q_full, q_push, q_pop, q_not_empty;
  aplm_pkg::work_t q_wdata, q_rdata;

  assign window_wr = cfg_we && (cfg_index == aplm_pkg::CFG_WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r <= '0;
      attack_r  <= aplm_pkg::ATTACK_RESET;
      decay_r   <= aplm_pkg::DECAY_RESET;
      window_r  <= aplm_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aplm_pkg::CFG_CHANNEL: channel_r <= cfg_wdata[aplm_pkg::CHAN_W-1:0];
        aplm_pkg::CFG_ATTACK:  attack_r  <= cfg_wdata;
        aplm_pkg::CFG_DECAY:   decay_r   <= cfg_wdata;
        aplm_pkg::CFG_WINDOW:  window_r  <= cfg_wdata[aplm_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  aplm_front u_front (
    .sel_channel (channel_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  aplm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  aplm_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .attack_coef   (attack_r),
    .decay_coef    (decay_r),
    .window_length (window_r),
    .window_wr     (window_wr),
    .q_not_empty   (q_not_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

// ----- src/aplm_checker.sv -----
module aplm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input aplm_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("report dropped or changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report present after reset");

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.clip_seen || out_data.buffer_peak[17:16] != 2'b00))
    else $error("clip reported with peak below full scale");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((!out_data.buffer_peak[17] || out_data.buffer_peak[16:0] == '0) &&
                   (!out_data.rms_level[17] || out_data.rms_level[16:0] == '0)))
    else $error("level above largest magnitude");

endmodule

bind audio_peak_rms_level_meter_unit aplm_checker u_aplm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int RING_DEPTH = 16384;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  aplm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  aplm_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [aplm_pkg::CFG_IDX_W-1:0] cfg_index = aplm_pkg::CFG_CHANNEL;
  logic [aplm_pkg::COEF_W-1:0] cfg_wdata = '0;

  // travels with each request: a marked row whose report is known by inspection
  logic row_known = 1'b0;

  audio_peak_rms_level_meter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // meter state mirror
  longint unsigned sq_ring [RING_DEPTH];
  int unsigned ring_pos;
  longint unsigned sq_sum;
  longint unsigned env_lvl;
  longint unsigned peak_lvl;
  bit clip_lvl;
  int unsigned sel_chan;
  longint unsigned atk_coef;
  longint unsigned dcy_coef;
  int unsigned win_len;

  aplm_pkg::out_t report_q[$];
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;
  int unsigned requests_taken = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_left = 0;
  logic hold_go = 1'b0;
  longint unsigned cycles = 0;

  function automatic int unsigned window_eff();
    if (win_len == 0) return 1;
    if (win_len > RING_DEPTH) return RING_DEPTH;
    return win_len;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic clear_window();
    foreach (sq_ring[i]) sq_ring[i] = 0;
    ring_pos = 0;
    sq_sum = 0;
  endtask

  task automatic meter_reset();
    sel_chan = 0;
    atk_coef = 64'(aplm_pkg::ATTACK_RESET);
    dcy_coef = 64'(aplm_pkg::DECAY_RESET);
    win_len = 32'(aplm_pkg::WINDOW_RESET);
    clear_window();
    env_lvl = 0;
    peak_lvl = 0;
    clip_lvl = 0;
  endtask

  task automatic meter_write(logic [aplm_pkg::CFG_IDX_W-1:0] idx,
                             logic [aplm_pkg::COEF_W-1:0] val);
    case (idx)
      aplm_pkg::CFG_CHANNEL: sel_chan = 32'(val[aplm_pkg::CHAN_W-1:0]);
      aplm_pkg::CFG_ATTACK:  atk_coef = 64'(val);
      aplm_pkg::CFG_DECAY:   dcy_coef = 64'(val);
      aplm_pkg::CFG_WINDOW: begin
        win_len = 32'(val[aplm_pkg::WLEN_W-1:0]);
        clear_window();
      end
      default: ;
    endcase
  endtask

  task automatic meter_step(aplm_pkg::in_t it, output bit has, output aplm_pkg::out_t r);
    longint s;
    longint unsigned mag, sq, a;
    int unsigned p, w;
    has = 1'b0;
    r = '0;
    if (it.sample_channel == sel_chan) begin
      s = $signed(it.sample_value);
      mag = (s < 0) ? -s : s;
      sq = mag * mag;
      w = window_eff();
      p = (ring_pos >= w) ? 0 : ring_pos;
      if (mag >= 65536) clip_lvl = 1'b1;
      sq_sum = (sq_sum + sq - sq_ring[p]) & ((64'd1 << aplm_pkg::SUM_W) - 1);
      sq_ring[p] = sq;
      p++;
      ring_pos = (p >= w) ? 0 : p;
      if (mag > peak_lvl) peak_lvl = mag;
      a = (mag > env_lvl) ? atk_coef : dcy_coef;
      env_lvl = ((mag * (65536 - a) + a * env_lvl + 32768) >> 16) & 64'h3FFFF;
    end
    if (it.buffer_end) begin
      has = 1'b1;
      r.buffer_peak = peak_lvl[aplm_pkg::SAMPLE_W-1:0];
      r.clip_seen = clip_lvl;
      r.envelope_level = env_lvl[aplm_pkg::SAMPLE_W-1:0];
      r.rms_level = aplm_pkg::SAMPLE_W'(floor_root(sq_sum / window_eff()));
      peak_lvl = 0;
      clip_lvl = 0;
    end
  endtask

  function automatic bit report_differs(aplm_pkg::out_t e, aplm_pkg::out_t g);
    return e.buffer_peak !== g.buffer_peak || e.clip_seen !== g.clip_seen ||
           e.envelope_level !== g.envelope_level || e.rms_level !== g.rms_level;
  endfunction

  // mirror config writes and requests, check reports
  always @(posedge clk) begin
    bit has;
    aplm_pkg::out_t r;
    aplm_pkg::out_t e;
    if (rst_n) begin
      if (cfg_we) meter_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        requests_taken++;
        meter_step(in_data, has, r);
        if (has) report_q.push_back(row_known ? aplm_pkg::out_t'('0) : r);
      end
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected report %p", out_data);
        end else begin
          e = report_q.pop_front();
          if (report_differs(e, out_data)) begin
            mismatches++;
            if (mismatches <= 10) $display("report mismatch: expected %p got %p", e, out_data);
          end
        end
      end
    end
  end

  // receiver: long hold-off when asked, random stall otherwise
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycles, report_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(aplm_pkg::in_t it, bit known);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_known <= known;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    row_known <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // one write, then cfg_we dropped before returning so back-to-back writes never collide
  task automatic write_reg(logic [aplm_pkg::CFG_IDX_W-1:0] idx,
                           logic [aplm_pkg::COEF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic aplm_pkg::in_t random_request(int unsigned chan_pct,
                                                   int unsigned mark_pct);
    aplm_pkg::in_t it;
    it.sample_channel = ($urandom_range(99) < chan_pct) ?
                        sel_chan[aplm_pkg::CHAN_W-1:0] :
                        aplm_pkg::CHAN_W'($urandom_range(15));
    case ($urandom_range(7))
      0: it.sample_value = -18'sd131071 - 18'sd1;
      1: it.sample_value = 18'sd131071;
      2: it.sample_value = aplm_pkg::SAMPLE_W'(int'($urandom_range(3)) - 2);
      3: it.sample_value = ($urandom_range(1) ? 18'sd65536 : -18'sd65536) +
                           $signed(18'($urandom_range(4))) - 18'sd2;
      default: it.sample_value = aplm_pkg::SAMPLE_W'($urandom);
    endcase
    it.buffer_end = ($urandom_range(99) < mark_pct);
    return it;
  endfunction

  typedef struct {
    int sv;
    int ch;
    bit last;
    bit known;  // report is all zeros by inspection
  } row_t;

  row_t rows[] = '{
    '{0, 0, 1'b1, 1'b1},
    '{77777, 7, 1'b1, 1'b1},
    '{131071, 0, 1'b0, 1'b0},
    '{-131072, 0, 1'b1, 1'b0},
    '{65536, 0, 1'b1, 1'b0},
    '{65535, 0, 1'b1, 1'b0},
    '{-65536, 0, 1'b0, 1'b0},
    '{-65537, 0, 1'b1, 1'b0},
    '{-1, 0, 1'b0, 1'b0},
    '{1, 0, 1'b1, 1'b0},
    '{131071, 15, 1'b1, 1'b0},
    '{-131072, 3, 1'b0, 1'b0},
    '{0, 0, 1'b1, 1'b0},
    '{0, 0, 1'b1, 1'b0}
  };

  initial begin
    aplm_pkg::in_t it;
    int unsigned win_pick;
    meter_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      it.sample_value = aplm_pkg::SAMPLE_W'(rows[i].sv);
      it.sample_channel = aplm_pkg::CHAN_W'(rows[i].ch);
      it.buffer_end = rows[i].last;
      send_request(it, rows[i].known);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: win_pick = 0;
        1: win_pick = 32767;
        2: win_pick = 1;
        3: win_pick = 16384;
        default: win_pick = $urandom_range(2, 40);
      endcase
      write_reg(aplm_pkg::CFG_CHANNEL,
                aplm_pkg::COEF_W'((ph == 1) ? 15 : (ph == 2) ? 0 : $urandom_range(15)));
      write_reg(aplm_pkg::CFG_ATTACK,
                aplm_pkg::COEF_W'((ph == 0) ? 0 : (ph == 1) ? 32'hFFFF : $urandom));
      write_reg(aplm_pkg::CFG_DECAY,
                aplm_pkg::COEF_W'((ph == 0) ? 32'hFFFF : (ph == 1) ? 0 : $urandom));
      write_reg(aplm_pkg::CFG_WINDOW, aplm_pkg::COEF_W'(win_pick));
      in_idle_pct = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 9 : 0;
      out_stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 9 : 0;
      if (ph == 2) begin
        // hold the receiver off while requests keep coming
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (int n = 0; n < 230; n++) begin
        if (ph == 5 && n == 115) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (report_q.size() != 0) @(posedge clk);
        end
        send_request(random_request(75, (ph == 2 && n < 40) ? 50 : 12), 1'b0);
      end
      drain();
    end

    $display("%0d requests taken, %0d reports checked over 8 register settings",
             requests_taken, reports_seen);
    $display("windows 0, 1, max and above max, coefficient extremes, stalls and hold-off");
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d reports missing", mismatches, report_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
